// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define TSLM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// signal keeps its value in the cycle after the condition
`define TSLM_ASSERT_HOLD(label, clk, rstn, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

// File: design/tslm_pkg.sv
package tslm_pkg;

    localparam int unsigned TSLM_LIST_DEPTH = 256;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_ORDER    = 2'd2;

    typedef struct packed {
        logic               list_select;
        logic signed [31:0] value;
        logic               last;
    } tslm_in_t;

    typedef struct packed {
        logic signed [32:0] median_doubled;
        logic [1:0]         status;
    } tslm_out_t;

endpackage

// File: design/two_sorted_list_median.sv
// Median of two ascending lists. Each input request appends one signed 32-bit value to the
// first or second list, one request per cycle while loading; a request with last set closes
// the set. The result is twice the median of both lists together (the sum of the two middle
// values for an even total), with status 1 when an append to a full list was dropped and
// status 2, taking priority, median 0, when a list was not nondecreasing. After the last
// request the block merges from the front of both lists: with m the total count halved and
// rounded down it takes m+1 merge steps, each one registered read per list store and then
// the compare, then registers the result; with a list error it skips the merge. The stores
// are plain single-port memories with no clearing pass: only entries below the fill counts
// are used. The next set may be loaded while the result waits.
module two_sorted_list_median #(
    parameter int unsigned LIST_DEPTH = tslm_pkg::TSLM_LIST_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tslm_pkg::tslm_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tslm_pkg::tslm_out_t m_data
);
    import tslm_pkg::*;

    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
    localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    typedef logic [1:0] step_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_LAST,
        COND_ORDER,
        COND_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  accept_en;
        logic  rd_en;
        logic  pick_en;
        logic  emit_en;
        cond_t cond;
        step_t target;
    } ctl_word_t;

    localparam step_t ST_LOAD = 2'd0;
    localparam step_t ST_READ = 2'd1;
    localparam step_t ST_PICK = 2'd2;
    localparam step_t ST_EMIT = 2'd3;

    function automatic ctl_word_t ucode(input step_t step);
        ctl_word_t w;
        w = '0;
        w.cond = COND_NEVER;
        w.target = ST_LOAD;
        case (step)
            ST_LOAD: begin
                w.accept_en = 1'b1;
                w.cond      = COND_NO_LAST;
                w.target    = ST_LOAD;
            end
            ST_READ: begin
                w.rd_en  = 1'b1;
                w.cond   = COND_ORDER;
                w.target = ST_EMIT;
            end
            ST_PICK: begin
                w.pick_en = 1'b1;
                w.cond    = COND_MORE;
                w.target  = ST_READ;
            end
            ST_EMIT: begin
                w.emit_en = 1'b1;
                w.cond    = COND_OUT_BUSY;
                w.target  = ST_EMIT;
            end
            default: begin
                w.cond   = COND_NEVER;
                w.target = ST_LOAD;
            end
        endcase
        return w;
    endfunction

    logic signed [31:0] mem_a [LIST_DEPTH];
    logic signed [31:0] mem_b [LIST_DEPTH];

    step_t              step_reg, step_next;
    logic [CW-1:0]      cnt_a_reg, cnt_a_next;
    logic [CW-1:0]      cnt_b_reg, cnt_b_next;
    logic [CW-1:0]      ptr_a_reg, ptr_a_next;
    logic [CW-1:0]      ptr_b_reg, ptr_b_next;
    logic [CW-1:0]      pick_cnt_reg, pick_cnt_next;
    logic               ovf_reg, ovf_next;
    logic               ord_reg, ord_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] tail_a_reg, tail_b_reg;
    logic signed [31:0] rd_a_reg, rd_b_reg;
    logic signed [31:0] cur_reg, prev_reg;
    tslm_out_t          m_data_reg, result;

    ctl_word_t          ctl;
    logic               accept, append, full, descend, jump, emit, out_busy;
    logic               take_first, more, sel;
    logic [CW-1:0]      cnt_sel;
    logic signed [31:0] tail_sel, picked;
    logic [CW:0]        total;
    logic [CW-1:0]      half;

    always_comb begin
        ctl      = ucode(step_reg);
        s_ready  = ctl.accept_en;
        accept   = s_valid && ctl.accept_en;
        sel      = s_data.list_select;
        cnt_sel  = sel ? cnt_b_reg : cnt_a_reg;
        tail_sel = sel ? tail_b_reg : tail_a_reg;
        full     = (cnt_sel == DEPTH_C);
        append   = accept && !full;
        descend  = (cnt_sel != '0) && (s_data.value < tail_sel);

        total = {1'b0, cnt_a_reg} + {1'b0, cnt_b_reg};
        half  = total[CW:1];

        take_first = (ptr_b_reg >= cnt_b_reg)
                     || ((ptr_a_reg < cnt_a_reg) && (rd_a_reg <= rd_b_reg));
        picked   = take_first ? rd_a_reg : rd_b_reg;
        more     = (pick_cnt_reg != half);
        out_busy = m_valid_reg && !m_ready;

        case (ctl.cond)
            COND_NEVER:    jump = 1'b0;
            COND_NO_LAST:  jump = !(accept && s_data.last);
            COND_ORDER:    jump = ord_reg;
            COND_MORE:     jump = more;
            COND_OUT_BUSY: jump = out_busy;
            default:       jump = 1'b0;
        endcase
        step_next = jump ? ctl.target : step_reg + 2'd1;
        emit      = ctl.emit_en && !out_busy;

        cnt_a_next    = cnt_a_reg;
        cnt_b_next    = cnt_b_reg;
        ovf_next      = ovf_reg;
        ord_next      = ord_reg;
        ptr_a_next    = ptr_a_reg;
        ptr_b_next    = ptr_b_reg;
        pick_cnt_next = pick_cnt_reg;

        if (append && !sel) begin
            cnt_a_next = cnt_a_reg + 1'b1;
        end
        if (append && sel) begin
            cnt_b_next = cnt_b_reg + 1'b1;
        end
        if (accept && full) begin
            ovf_next = 1'b1;
        end
        if (append && descend) begin
            ord_next = 1'b1;
        end
        if (ctl.pick_en) begin
            pick_cnt_next = pick_cnt_reg + 1'b1;
            if (take_first) begin
                ptr_a_next = ptr_a_reg + 1'b1;
            end else begin
                ptr_b_next = ptr_b_reg + 1'b1;
            end
        end
        if (emit) begin
            cnt_a_next    = '0;
            cnt_b_next    = '0;
            ovf_next      = 1'b0;
            ord_next      = 1'b0;
            ptr_a_next    = '0;
            ptr_b_next    = '0;
            pick_cnt_next = '0;
        end

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end

        if (ord_reg) begin
            result.median_doubled = '0;
            result.status         = STATUS_ORDER;
        end else begin
            if (total[0]) begin
                result.median_doubled = {cur_reg, 1'b0};
            end else begin
                result.median_doubled = {prev_reg[31], prev_reg} + {cur_reg[31], cur_reg};
            end
            result.status = ovf_reg ? STATUS_OVERFLOW : STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= ST_LOAD;
            cnt_a_reg    <= '0;
            cnt_b_reg    <= '0;
            ovf_reg      <= 1'b0;
            ord_reg      <= 1'b0;
            ptr_a_reg    <= '0;
            ptr_b_reg    <= '0;
            pick_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            step_reg     <= step_next;
            cnt_a_reg    <= cnt_a_next;
            cnt_b_reg    <= cnt_b_next;
            ovf_reg      <= ovf_next;
            ord_reg      <= ord_next;
            ptr_a_reg    <= ptr_a_next;
            ptr_b_reg    <= ptr_b_next;
            pick_cnt_reg <= pick_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (append && !sel) begin
            tail_a_reg <= s_data.value;
        end
        if (append && sel) begin
            tail_b_reg <= s_data.value;
        end
        if (ctl.pick_en) begin
            cur_reg  <= picked;
            prev_reg <= cur_reg;
        end
        if (emit) begin
            m_data_reg <= result;
        end
    end

    // list stores
    always_ff @(posedge aclk) begin
        if (append && !sel) begin
            mem_a[cnt_a_reg[AW-1:0]] <= s_data.value;
        end
        if (append && sel) begin
            mem_b[cnt_b_reg[AW-1:0]] <= s_data.value;
        end
        if (ctl.rd_en) begin
            rd_a_reg <= mem_a[ptr_a_reg[AW-1:0]];
            rd_b_reg <= mem_b[ptr_b_reg[AW-1:0]];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: design/tslm_checker.sv
`include "assert_macros.svh"

module tslm_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input tslm_pkg::tslm_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input tslm_pkg::tslm_out_t m_data
);
    import tslm_pkg::*;

    logic in_req;
    assign in_req = s_valid && s_ready && s_data.last;

    `TSLM_ASSERT(a_result_held, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `TSLM_ASSERT_HOLD(a_result_stable, aclk, aresetn, m_valid && !m_ready, m_data, "result changed while stalled")
    `TSLM_ASSERT(a_order_zero, aclk, aresetn, m_valid && (m_data.status == STATUS_ORDER) |-> (m_data.median_doubled == '0), "order error with nonzero median")
    `TSLM_ASSERT(a_status_code, aclk, aresetn, m_valid |-> (m_data.status == STATUS_OK || m_data.status == STATUS_OVERFLOW || m_data.status == STATUS_ORDER), "undefined status code")
    `TSLM_ASSERT(a_no_early_result, aclk, aresetn, in_req |=> !$rose(m_valid), "result before search")

endmodule

bind two_sorted_list_median tslm_checker u_tslm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: bench/two_sorted_list_median_check.sv
`timescale 1ns / 1ps

module two_sorted_list_median_check
    import tslm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  tslm_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  tslm_out_t m_data,
    output int        mismatches,
    output int        pending,
    output int        results_seen
);

    localparam int unsigned DEPTH = TSLM_LIST_DEPTH;

    logic signed [31:0] first_list [DEPTH];
    logic signed [31:0] second_list [DEPTH];
    int unsigned        first_fill;
    int unsigned        second_fill;
    bit                 dropped_append;
    bit                 out_of_order;
    tslm_out_t          medians_due [$];

    // k-th smallest of both lists together, counted from zero
    function automatic logic signed [31:0] merged_rank(input int unsigned k);
        int unsigned        a;
        int unsigned        b;
        int unsigned        i;
        logic signed [31:0] picked;
        a = 0;
        b = 0;
        picked = '0;
        for (i = 0; i <= k; i++) begin
            if (b >= second_fill || (a < first_fill && first_list[a] <= second_list[b])) begin
                picked = first_list[a];
                a++;
            end else begin
                picked = second_list[b];
                b++;
            end
        end
        return picked;
    endfunction

    function automatic tslm_out_t predict_median();
        tslm_out_t          r;
        int unsigned        total;
        logic signed [32:0] lo;
        logic signed [32:0] hi;
        total = first_fill + second_fill;
        r.median_doubled = '0;
        r.status = STATUS_OK;
        if (out_of_order) begin
            r.status = STATUS_ORDER;
        end else begin
            if (total > 0) begin
                lo = merged_rank((total - 1) / 2);
                hi = (total % 2 == 1) ? lo : merged_rank(total / 2);
                r.median_doubled = lo + hi;
            end
            if (dropped_append) begin
                r.status = STATUS_OVERFLOW;
            end
        end
        return r;
    endfunction

    function automatic void clear_lists();
        first_fill = 0;
        second_fill = 0;
        dropped_append = 1'b0;
        out_of_order = 1'b0;
    endfunction

    function automatic void take_request(input tslm_in_t req);
        if (req.list_select) begin
            if (second_fill >= DEPTH) begin
                dropped_append = 1'b1;
            end else begin
                if (second_fill > 0 && $signed(req.value) < second_list[second_fill - 1]) begin
                    out_of_order = 1'b1;
                end
                second_list[second_fill] = req.value;
                second_fill++;
            end
        end else begin
            if (first_fill >= DEPTH) begin
                dropped_append = 1'b1;
            end else begin
                if (first_fill > 0 && $signed(req.value) < first_list[first_fill - 1]) begin
                    out_of_order = 1'b1;
                end
                first_list[first_fill] = req.value;
                first_fill++;
            end
        end
        if (req.last) begin
            medians_due.push_back(predict_median());
            clear_lists();
        end
    endfunction

    always @(posedge aclk) begin
        tslm_out_t want;
        if (!aresetn) begin
            clear_lists();
            medians_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (medians_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result median_doubled %0d status %0d",
                                 $realtime, m_data.median_doubled, m_data.status);
                    end
                end else begin
                    want = medians_due.pop_front();
                    if (m_data.median_doubled !== want.median_doubled ||
                        m_data.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: median_doubled exp %0d got %0d, status exp %0d got %0d",
                                     $realtime, want.median_doubled, m_data.median_doubled,
                                     want.status, m_data.status);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                take_request(s_data);
            end
        end
        pending = medians_due.size();
    end

endmodule

// File: bench/two_sorted_list_median_tb.sv
`timescale 1ns / 1ps

module two_sorted_list_median_tb;
    import tslm_pkg::*;

    localparam int ITEM_TARGET  = 1650;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 540;

    typedef logic signed [31:0] word_t;
    typedef word_t word_q_t [$];
    typedef enum {SPREAD_FULL, SPREAD_NARROW, SPREAD_EDGES} spread_t;

    localparam word_t WORD_MAX = 32'h7fff_ffff;
    localparam word_t WORD_MIN = 32'h8000_0000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    tslm_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    tslm_out_t m_data;

    int mismatches;
    int pending;
    int results_seen;
    int requests_sent;
    int sets_sent;
    int overflow_sets;
    int disorder_sets;
    bit no_gaps;

    two_sorted_list_median uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    two_sorted_list_median_check median_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("end of test: mismatches");
        $finish;
    end

    // result side back-pressure
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic push_request(input tslm_in_t req);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // sends both lists interleaved at random, order within each list kept
    task automatic play_set(input word_q_t qa, input word_q_t qb, input bit hold_b);
        tslm_in_t req;
        word_t    tail;
        bit       tail_held;
        tail_held = hold_b && qb.size() > 0;
        if (tail_held) begin
            tail = qb.pop_back();
        end
        while (qa.size() + qb.size() > 0) begin
            req.list_select = (qa.size() == 0) || (qb.size() > 0 && $urandom_range(0, 1) == 1);
            req.value = req.list_select ? qb.pop_front() : qa.pop_front();
            req.last = !tail_held && (qa.size() + qb.size() == 0);
            push_request(req);
        end
        if (tail_held) begin
            req.list_select = 1'b1;
            req.value = tail;
            req.last = 1'b1;
            push_request(req);
        end
        sets_sent++;
    endtask

    function automatic word_t draw_value(input spread_t spread);
        case (spread)
            SPREAD_FULL:   return word_t'($urandom);
            SPREAD_NARROW: return word_t'($urandom_range(0, 8)) - 32'sd4;
            default: begin
                case ($urandom_range(0, 4))
                    0:       return WORD_MIN;
                    1:       return WORD_MAX;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    default: return word_t'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic void build_list(input int n, input spread_t spread, output word_q_t q);
        word_t v;
        int    pos;
        q = {};
        repeat (n) begin
            v = draw_value(spread);
            pos = 0;
            while (pos < q.size() && q[pos] <= v) pos++;
            q.insert(pos, v);
        end
    endfunction

    // puts at least one descending step into an ascending list of two or more values
    function automatic bit break_order(ref word_q_t q);
        int j;
        if (q.size() < 2) begin
            return 1'b0;
        end
        j = $urandom_range(1, q.size() - 1);
        if (q[j - 1] == WORD_MIN) begin
            q[j - 1] = 32'sd1;
            q[j] = 32'sd0;
        end else begin
            q[j] = q[j - 1] - 32'sd1;
        end
        return 1'b1;
    endfunction

    initial begin
        word_q_t qa;
        word_q_t qb;
        spread_t spread;
        int      big;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes, mixed lists, duplicates, descending steps
        qa = {WORD_MAX};                  qb = {};                        play_set(qa, qb, 0);
        qa = {};                          qb = {WORD_MIN};                play_set(qa, qb, 0);
        qa = {WORD_MAX};                  qb = {WORD_MAX};                play_set(qa, qb, 0);
        qa = {WORD_MIN};                  qb = {WORD_MIN};                play_set(qa, qb, 0);
        qa = {WORD_MIN};                  qb = {WORD_MAX};                play_set(qa, qb, 0);
        qa = {-32'sd5, 32'sd3};           qb = {-32'sd1, 32'sd7, 32'sd7}; play_set(qa, qb, 0);
        qa = {32'sd10, 32'sd2};           qb = {};                        play_set(qa, qb, 0);
        qa = {WORD_MIN};                  qb = {32'sd0, -32'sd1};         play_set(qa, qb, 0);
        qa = {32'sd4, 32'sd4};            qb = {32'sd4};                  play_set(qa, qb, 0);
        qa = {};
        qb = {32'sd1, 32'sd2, 32'sd3, 32'sd4};
        play_set(qa, qb, 1);
        disorder_sets += 2;
        wait_drained();

        big = 0;
        while (requests_sent < ITEM_TARGET) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            if (big < 3 && requests_sent >= 200 + big * 400) begin
                // lists past full depth
                case (big)
                    0: begin
                        build_list(259, SPREAD_FULL, qa);
                        build_list(3, SPREAD_EDGES, qb);
                    end
                    1: begin
                        build_list(4, SPREAD_NARROW, qa);
                        build_list(258, SPREAD_FULL, qb);
                    end
                    default: begin
                        build_list(257, SPREAD_EDGES, qa);
                        build_list(6, SPREAD_FULL, qb);
                        void'(break_order(qb));
                        disorder_sets++;
                    end
                endcase
                play_set(qa, qb, 0);
                overflow_sets++;
                big++;
            end else begin
                spread = spread_t'($urandom_range(0, 2));
                build_list(($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) :
                           $urandom_range(0, 10), spread, qa);
                build_list(($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) :
                           $urandom_range(0, 10), spread, qb);
                if (qa.size() + qb.size() == 0) begin
                    qa.push_back(draw_value(spread));
                end
                if ($urandom_range(0, 9) == 0) begin
                    if (break_order(qa) || break_order(qb)) begin
                        disorder_sets++;
                    end
                end
                play_set(qa, qb, $urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 19) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d requests in %0d sets, %0d past full depth, %0d out of order",
                 requests_sent, sets_sent, overflow_sets, disorder_sets);
        $display("%0d medians compared, %0d mismatched", results_seen, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/tslm_pkg.sv
design/two_sorted_list_median.sv
design/tslm_checker.sv
bench/two_sorted_list_median_check.sv
bench/two_sorted_list_median_tb.sv
